[rtl/ptd_pkg.sv]
// Package for the periodic task dispatcher: field widths, defaults,
// request kind codes, scan state encoding and the scan status bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

    // Fixed widths of the request and result fields
    localparam int IN_TIME_W  = 24;
    localparam int IN_IDX_W   = 3;
    localparam int TICK_LEN_W = 10;
    localparam int DUE_IDX_W  = 3;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF  = 8;
    localparam int TIME_WIDTH_DEF = 24;

    // Tick length after reset
    localparam logic [TICK_LEN_W-1:0] TICK_LEN_RESET = TICK_LEN_W'(1);

    // Request kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } scan_state_t;

    // Status of the scan engine seen by the top level
    typedef struct packed {
        logic busy;        // a tick is being processed
        logic pend_valid;  // a due slot waits for its last flag
        logic hold;        // scan halted behind a stalled result
    } scan_status_t;

endpackage

`default_nettype wire

[rtl/periodic_task_dispatcher_top.sv]
// Periodic task dispatcher, top level: tick length register and scan engine.
// Depends on ptd_pkg, ptd_scan and ptd_slot_mem.
//
// Usage:
//   Request channel (in_valid / in_stall): kind selects a tick or a slot load.
//   A load writes period, first delay and enable of one slot, gives no result
//   and is dropped beyond the table. A tick scans all slots in index order,
//   one slot per cycle through the slot memory read port unless halted.
//   Result channel (out_valid / out_stall): one result per due slot, in index
//   order, last_due set on the final one. A tick with nothing due gives none.
//   A load leaves the request side free for the next request at once; a tick
//   keeps it stalled until its scan and flush are done, since the single
//   read port walks the slot memory.
//   Latency: a due slot is shown once the next due slot is found, or at the
//   end of the scan for the last one.
//   A stalled result holds; a further due slot then halts the scan until the
//   held result is taken. in_stall stays high for the whole tick.
//   cfg_wr_en / cfg_wr_data set the tick length (ms); write only while idle.
//   Reset: all slots disabled, tick length 1, no results pending.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher_top
    import ptd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [TICK_LEN_W-1:0] cfg_wr_data,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic                  kind,
    input  wire logic [IN_IDX_W-1:0]   slot_index,
    input  wire logic [IN_TIME_W-1:0]  period_ms,
    input  wire logic [IN_TIME_W-1:0]  first_delay_ms,
    input  wire logic                  slot_enabled,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [DUE_IDX_W-1:0]  due_index,
    output      logic                  last_due
);

    logic [TICK_LEN_W-1:0] tick_len_reg;
    scan_status_t          status;

    // Tick length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg <= TICK_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            tick_len_reg <= cfg_wr_data;
        end
    end

    ptd_scan #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_len       (tick_len_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .slot_index     (slot_index),
        .period_ms      (period_ms),
        .first_delay_ms (first_delay_ms),
        .slot_enabled   (slot_enabled),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .due_index      (due_index),
        .last_due       (last_due),
        .status         (status)
    );

`ifndef ASSERT_OFF
    // No due slot may be left pending once the engine is idle
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> !status.pend_valid)
        else $error("pending due slot while idle");

    // A result without the last flag always has a successor waiting
    a_not_last_has_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_due) |-> status.pend_valid)
        else $error("non-final result with no following due slot");

    // The scan halts only behind a stalled result with another due waiting
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        status.hold |-> (status.pend_valid && out_valid && out_stall && status.busy))
        else $error("scan halted without a stalled result");
`endif

endmodule

`default_nettype wire

[rtl/ptd_slot_mem.sv]
// Slot memory: reload period and remaining time per task slot.
// One write port, one read port with a registered read.
// Depends on ptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptd_slot_mem
    import ptd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [SLOT_W-1:0]     wr_addr,
    input  wire logic [TIME_WIDTH-1:0] wr_period,
    input  wire logic [TIME_WIDTH-1:0] wr_remain,
    input  wire logic                  rd_en,
    input  wire logic [SLOT_W-1:0]     rd_addr,
    output      logic [TIME_WIDTH-1:0] rd_period,
    output      logic [TIME_WIDTH-1:0] rd_remain
);

    logic [2*TIME_WIDTH-1:0] slot_mem [NUM_SLOTS];
    logic [2*TIME_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= {wr_period, wr_remain};
        end
    end

    // Registered read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_period = rd_data_reg[2*TIME_WIDTH-1:TIME_WIDTH];
    assign rd_remain = rd_data_reg[TIME_WIDTH-1:0];

endmodule

`default_nettype wire

[rtl/ptd_scan.sv]
// Scan engine: takes load and tick requests, walks the slot memory one slot per
// cycle on a tick unless halted, and emits due slot indices with a last flag.
// Depends on ptd_pkg and ptd_slot_mem.
`timescale 1ns / 1ps
`default_nettype none

module ptd_scan
    import ptd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [TICK_LEN_W-1:0] tick_len,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic                  kind,
    input  wire logic [IN_IDX_W-1:0]   slot_index,
    input  wire logic [IN_TIME_W-1:0]  period_ms,
    input  wire logic [IN_TIME_W-1:0]  first_delay_ms,
    input  wire logic                  slot_enabled,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [DUE_IDX_W-1:0]  due_index,
    output      logic                  last_due,
    output      scan_status_t          status
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (TIME_WIDTH > TICK_LEN_W) ? TIME_WIDTH : TICK_LEN_W;

    scan_state_t state_reg, state_next;

    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [SLOT_W-1:0]    s1_idx_reg, s1_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DUE_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                 out_last_reg, out_last_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;

    logic                  tick_accept, load_accept, load_ok;
    logic                  out_free, s1_active, s1_zero, s1_due;
    logic                  hold, issue, commit, flush_emit, scan_done;
    logic [TIME_WIDTH-1:0] rd_period, rd_remain, base_time, new_remain;
    logic [CMP_W-1:0]      base_ext, tick_ext;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [TIME_WIDTH-1:0] mem_wperiod, mem_wremain;

    // Request handshake
    assign tick_accept = in_valid && !in_stall && (kind == KIND_TICK);
    assign load_accept = in_valid && !in_stall && (kind == KIND_LOAD);
    assign load_ok     = load_accept && (32'(slot_index) < NUM_SLOTS);

    // Scan pipeline: read stage then modify stage
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_active  = active_reg[s1_idx_reg];
    assign s1_zero    = (rd_remain == '0);
    assign s1_due     = s1_valid_reg && s1_active && s1_zero;
    assign hold       = s1_due && pend_valid_reg && !out_free;
    assign issue      = (state_reg == ST_SCAN) && (rd_idx_reg < CNT_W'(NUM_SLOTS)) && !hold;
    assign commit     = s1_valid_reg && !hold;
    assign scan_done  = (rd_idx_reg == CNT_W'(NUM_SLOTS)) && !s1_valid_reg;

    // Reload on due, then saturating subtract of the tick length
    always_comb
    begin
        base_time  = (s1_active && s1_zero) ? rd_period : rd_remain;
        base_ext   = CMP_W'(base_time);
        tick_ext   = CMP_W'(tick_len);
        new_remain = (base_ext > tick_ext) ? TIME_WIDTH'(base_ext - tick_ext) : '0;
    end

    // Memory write mux: loads only happen while idle, scan writes only while busy
    always_comb
    begin
        if (load_ok)
        begin
            mem_we      = 1'b1;
            mem_waddr   = SLOT_W'(slot_index);
            mem_wperiod = TIME_WIDTH'(period_ms);
            mem_wremain = TIME_WIDTH'(first_delay_ms);
        end
        else
        begin
            mem_we      = commit && s1_active;
            mem_waddr   = s1_idx_reg;
            mem_wperiod = rd_period;
            mem_wremain = new_remain;
        end
    end

    ptd_slot_mem #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_slot_mem (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_period (mem_wperiod),
        .wr_remain (mem_wremain),
        .rd_en     (issue),
        .rd_addr   (rd_idx_reg[SLOT_W-1:0]),
        .rd_period (rd_period),
        .rd_remain (rd_remain)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall   = 1'b1;
        flush_emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                in_stall = 1'b1;
            end
            ST_FLUSH:
            begin
                flush_emit = pend_valid_reg && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        active_next     = active_reg;

        if (load_ok)
        begin
            active_next[SLOT_W'(slot_index)] = slot_enabled;
        end

        if (tick_accept)
        begin
            rd_idx_next = '0;
        end

        // read stage
        if (!hold)
        begin
            s1_valid_next = issue;
            if (issue)
            begin
                s1_idx_next = rd_idx_reg[SLOT_W-1:0];
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
        end

        // modify stage: a new due slot pushes the pending one out
        if (commit && s1_due)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_idx_next   = DUE_IDX_W'(pend_idx_reg);
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = s1_idx_reg;
        end

        // end of scan: last due slot goes out flagged
        if (flush_emit)
        begin
            out_valid_next  = 1'b1;
            out_idx_next    = DUE_IDX_W'(pend_idx_reg);
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            active_reg     <= active_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign due_index = out_idx_reg;
    assign last_due  = out_last_reg;

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.pend_valid = pend_valid_reg;
    assign status.hold       = hold;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for periodic_task_dispatcher_top: drives slot loads and ticks with random gaps,
// predicts due slots in a scoreboard class and checks every result.
// Depends on ptd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_top;
    import ptd_pkg::*;

    localparam int SLOTS      = NUM_SLOTS_DEF;
    localparam int DRAIN_CYC  = 16;
    localparam int HOLD_CYC   = 400;
    localparam int PHASE_REQS = 50;

    // One expected due slot
    typedef struct packed {
        logic [DUE_IDX_W-1:0] idx;
        logic                 last;
    } due_t;

    // Scoreboard: keeps its own slot table and the queue of due slots still owed
    class dispatch_checker;
        logic [IN_TIME_W-1:0]  slot_time [SLOTS];
        logic [IN_TIME_W-1:0]  slot_period [SLOTS];
        logic                  slot_on [SLOTS];
        logic [TICK_LEN_W-1:0] tick_ms;
        due_t                  due_q[$];
        int                    errors;

        function new();
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_time[s]   = '0;
                slot_period[s] = '0;
                slot_on[s]     = 1'b0;
            end
            tick_ms = TICK_LEN_RESET;
            errors  = 0;
        endfunction

        // Update the slot table for an accepted request and queue the due slots of a tick
        function void note_request(logic k, logic [IN_IDX_W-1:0] idx,
                                   logic [IN_TIME_W-1:0] per, logic [IN_TIME_W-1:0] dly,
                                   logic en);
            int   hits[$];
            due_t d;
            if (k == KIND_LOAD)
            begin
                slot_period[idx] = per;
                slot_time[idx]   = dly;
                slot_on[idx]     = en;
                return;
            end
            for (int s = 0; s < SLOTS; s++)
            begin
                if (slot_on[s])
                begin
                    if (slot_time[s] == '0)
                    begin
                        hits.push_back(s);
                        slot_time[s] = slot_period[s];
                    end
                    // saturating countdown
                    if (slot_time[s] > IN_TIME_W'(tick_ms))
                        slot_time[s] = slot_time[s] - IN_TIME_W'(tick_ms);
                    else
                        slot_time[s] = '0;
                end
            end
            foreach (hits[i])
            begin
                d.idx  = DUE_IDX_W'(hits[i]);
                d.last = (i == hits.size() - 1);
                due_q.push_back(d);
            end
        endfunction

        // Compare one accepted result with the oldest due slot
        function void check_due(logic [DUE_IDX_W-1:0] idx, logic last);
            due_t d;
            if (due_q.size() == 0)
            begin
                $error("unexpected result: due_index %0d last_due %0d", idx, last);
                errors++;
                return;
            end
            d = due_q.pop_front();
            if (idx !== d.idx)
            begin
                $error("due_index mismatch: expected %0d, actual %0d", d.idx, idx);
                errors++;
            end
            if (last !== d.last)
            begin
                $error("last_due mismatch: expected %0d, actual %0d", d.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [TICK_LEN_W-1:0] cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [IN_IDX_W-1:0]   slot_index;
    logic [IN_TIME_W-1:0]  period_ms;
    logic [IN_TIME_W-1:0]  first_delay_ms;
    logic                  slot_enabled;
    logic                  out_valid;
    logic                  out_stall;
    logic [DUE_IDX_W-1:0]  due_index;
    logic                  last_due;

    dispatch_checker chk;
    bit              steady;        // no idle cycles on either side
    int              hold_cycles;   // long receiver hold-off, consumed by the receiver

    periodic_task_dispatcher_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .slot_index     (slot_index),
        .period_ms      (period_ms),
        .first_delay_ms (first_delay_ms),
        .slot_enabled   (slot_enabled),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .due_index      (due_index),
        .last_due       (last_due)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    // Offer one request after a random gap, return once it is accepted
    task automatic send_request(input logic k, input logic [IN_IDX_W-1:0] idx,
                                input logic [IN_TIME_W-1:0] per,
                                input logic [IN_TIME_W-1:0] dly, input logic en);
        int unsigned gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind           = k;
        slot_index     = idx;
        period_ms      = per;
        first_delay_ms = dly;
        slot_enabled   = en;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        chk.note_request(k, idx, per, dly, en);
    endtask

    task automatic send_tick();
        send_request(KIND_TICK, IN_IDX_W'($urandom), IN_TIME_W'($urandom),
                     IN_TIME_W'($urandom), 1'($urandom));
    endtask

    task automatic send_load(input int idx, input int per, input int dly, input logic en);
        send_request(KIND_LOAD, IN_IDX_W'(idx), IN_TIME_W'(per), IN_TIME_W'(dly), en);
    endtask

    // Mostly short times around the tick length so slots come due often
    function automatic logic [IN_TIME_W-1:0] pick_time(int unsigned tl);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '1;
        if (sel == 1)
            return '0;
        if (sel < 4)
            return IN_TIME_W'($urandom);
        return IN_TIME_W'($urandom_range(0, 4 * tl + 2));
    endfunction

    task automatic send_random(input int unsigned tl);
        logic                 k;
        logic [IN_TIME_W-1:0] per;
        logic [IN_TIME_W-1:0] dly;
        k   = ($urandom_range(0, 9) < 4) ? KIND_LOAD : KIND_TICK;
        per = pick_time(tl);
        dly = pick_time(tl);
        send_request(k, IN_IDX_W'($urandom), per, dly, 1'($urandom_range(0, 9) != 0));
    endtask

    // Stop offering and wait until every due slot has come out and the scan is done
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // Tick length write, only while idle
    task automatic set_tick_len(input int unsigned v);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = TICK_LEN_W'(v);
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        chk.tick_ms = TICK_LEN_W'(v);
    endtask

    task automatic random_phase(input int unsigned tl);
        set_tick_len(tl);
        repeat (PHASE_REQS) send_random(tl);
    endtask

    // Result side: random stall before each result, plus the long hold-off on request
    initial
    begin
        int unsigned gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                out_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = draw_gap();
            if (gap != 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            chk.check_due(due_index, last_due);
        end
    end

    // Stimulus
    initial
    begin
        chk            = new();
        steady         = 1'b0;
        hold_cycles    = 0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        kind           = KIND_TICK;
        slot_index     = '0;
        period_ms      = '0;
        first_delay_ms = '0;
        slot_enabled   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: fresh tick, extreme times, disabled slot, index extremes
        send_tick();
        send_load(0, 0, 0, 1'b1);
        send_load(7, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_load(3, 2, 0, 1'b0);
        send_load(5, 1, 0, 1'b1);
        send_tick();
        send_tick();
        send_load(3, 2, 0, 1'b1);
        send_tick();
        send_load(7, 0, 0, 1'b1);
        send_tick();
        send_load(0, 0, 0, 1'b0);
        send_tick();

        // Period shorter than the tick: due every tick once the first delay has run out
        set_tick_len(1000);
        send_load(2, 500, 999, 1'b1);
        send_tick();
        send_tick();
        send_tick();

        // Zero tick length: times hold, a slot with period zero stays due
        set_tick_len(0);
        send_load(4, 5, 0, 1'b1);
        send_load(6, 0, 0, 1'b1);
        send_tick();
        send_tick();
        send_tick();

        // Random phases over several tick lengths
        random_phase(1);
        random_phase(1000);
        random_phase($urandom_range(1, 1000));

        // Back-pressure: all slots due every tick, receiver holds off, sender keeps going
        set_tick_len(7);
        steady = 1'b1;
        for (int s = 0; s < SLOTS; s++)
            send_load(s, $urandom_range(0, 7), 0, 1'b1);
        hold_cycles = HOLD_CYC;
        repeat (20) send_tick();
        drain();

        // No idling on either side at tick length zero, then random gaps for two more phases
        random_phase(0);
        steady = 1'b0;
        random_phase(3);
        random_phase($urandom_range(1, 1000));

        drain();
        if (chk.errors == 0 && chk.pending() == 0)
            $display("periodic_task_dispatcher_top test passed");
        else
            $display("periodic_task_dispatcher_top test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("periodic_task_dispatcher_top test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/ptd_pkg.sv
rtl/ptd_slot_mem.sv
rtl/ptd_scan.sv
rtl/periodic_task_dispatcher_top.sv
dv/tb_top.sv
